@@ rtl/lcsg_pkg.sv @@
// ----------------------------------------------------------------------------
// lcsg_pkg: shared constants, types and sine table for the chirp generator
// Phase, table and sample widths, config register indexes and the quarter-wave
// sine ROM contents, built at elaboration.
// ----------------------------------------------------------------------------
package lcsg_pkg;

  localparam int PHASE_BITS      = 48;
  localparam int TABLE_ADDR_BITS = 12;
  localparam int SAMPLE_BITS     = 16;
  localparam int COUNT_BITS      = 24;

  localparam int AMP_BITS      = 15;
  localparam int AMP_FRAC      = 15;
  localparam int MAG_BITS      = SAMPLE_BITS - 1;
  localparam int PROD_BITS     = AMP_BITS + MAG_BITS;
  localparam int CNT_BITS      = COUNT_BITS + 1;   // run length incl. 2^COUNT_BITS
  localparam int QUARTER_BITS  = TABLE_ADDR_BITS - 2;
  localparam int QUARTER       = 1 << QUARTER_BITS;
  localparam int CFG_DATA_BITS = PHASE_BITS;

  localparam logic [CNT_BITS-1:0] MAX_COUNT   = CNT_BITS'(1) << COUNT_BITS;
  localparam logic [CNT_BITS-1:0] RESET_COUNT = CNT_BITS'(1024);

  // Config register indexes
  typedef enum logic [1:0] {
    REG_AMPLITUDE  = 2'd0,
    REG_START_INC  = 2'd1,
    REG_INC_STEP   = 2'd2,
    REG_SAMPLE_CNT = 2'd3
  } cfg_idx_t;

  // Table generation constants (unsigned Q2.30)
  localparam logic [63:0] Q30         = 64'd1 << 30;
  localparam logic [63:0] HALF30      = 64'd1 << 29;
  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
  localparam logic [63:0] QUARTER_64  = 64'd1 << QUARTER_BITS;
  localparam logic [63:0] FULL_SCALE  = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;

  // Reciprocals of the series divisors 2m(2m+1), m = 1..7, scaled by 2^41.
  // The dividend stays below 2^33, so the scaled product gives the exact
  // floor quotient.
  localparam int          RECIP_SHIFT = 41;
  localparam logic [63:0] RECIP [1:7] = '{
    ((64'd1 << RECIP_SHIFT) / 64'd6)   + 64'd1,
    ((64'd1 << RECIP_SHIFT) / 64'd20)  + 64'd1,
    ((64'd1 << RECIP_SHIFT) / 64'd42)  + 64'd1,
    ((64'd1 << RECIP_SHIFT) / 64'd72)  + 64'd1,
    ((64'd1 << RECIP_SHIFT) / 64'd110) + 64'd1,
    ((64'd1 << RECIP_SHIFT) / 64'd156) + 64'd1,
    ((64'd1 << RECIP_SHIFT) / 64'd210) + 64'd1
  };

  typedef logic [MAG_BITS-1:0] rom_t [QUARTER];

  // Quarter-wave sine magnitude, sampled at bin centers, Taylor series
  // evaluated in Horner form to fifteenth order.
  function automatic rom_t build_rom();
    rom_t         t;
    logic [63:0]  x;
    logic [63:0]  x2;
    logic [63:0]  r;
    logic [63:0]  d;
    logic [63:0]  y;
    logic [127:0] w;
    logic [63:0]  s;
    logic [63:0]  e;
    for (int k = 0; k < QUARTER; k++) begin
      x  = (PI_HALF_Q30 * 64'(2 * k + 1) + QUARTER_64) >> (QUARTER_BITS + 1);
      x2 = (x * x + HALF30) >> 30;
      r  = Q30;
      for (int m = 7; m >= 1; m--) begin
        d = 64'(2 * m * (2 * m + 1));
        y = (x2 * r + d * HALF30) >> 30;
        w = 128'(y) * 128'(RECIP[m]);
        r = Q30 - w[RECIP_SHIFT +: 64];
      end
      s    = (x * r + HALF30) >> 30;
      e    = (s * FULL_SCALE + HALF30) >> 30;
      t[k] = e[MAG_BITS-1:0];
    end
    return t;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

endpackage

@@ rtl/linear_chirp_sine_generator.sv @@
// ----------------------------------------------------------------------------
// linear_chirp_sine_generator: DDS tone and linear chirp source
// Phase accumulator with a ramping increment, quarter-wave sine ROM and
// amplitude scaling, one sample per input transfer.
// ----------------------------------------------------------------------------
// Usage
//   Input channel: each transfer (in_valid high, in_stall low) is one tick
//   and yields exactly one sample on the output channel. in_restart = 1 makes
//   that tick the first sample of a new run.
//   Output channel: out_sample (signed Q1.15) and out_last, which marks the
//   final sample of a run of sample_count samples; the run then rewinds.
//   Config port: cfg_we/cfg_addr/cfg_wdata write amplitude, start increment,
//   increment step and sample count. Write only while the block is idle.
// Pipeline
//   Four pipeline stages: state update, ROM read, multiply, round/output.
//   A sample passes the stage 1, 2 and 3 registers and the output register;
//   one transfer per cycle is sustained while out_stall is low. The loop
//   that sets the rate is the phase/increment update in stage 1.
// Reset
//   rst_n (synchronous) empties the pipeline, zeroes phase, increment and
//   run index, clears amplitude and increments, and sets the count to 1024.
// Stall
//   out_stall holds the output register; upstream stages keep filling empty
//   slots, and in_stall rises only once all four stages are occupied.
// ----------------------------------------------------------------------------
module linear_chirp_sine_generator (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_restart,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [lcsg_pkg::SAMPLE_BITS-1:0] out_sample,
  output logic                                  out_last,
  // config port
  input  logic                                  cfg_we,
  input  lcsg_pkg::cfg_idx_t                    cfg_addr,
  input  logic [lcsg_pkg::CFG_DATA_BITS-1:0]    cfg_wdata
);

  import lcsg_pkg::*;

  // --------------------------------------------------------------------------
  // Config registers
  // --------------------------------------------------------------------------
  logic [AMP_BITS-1:0]   amp_r;
  logic [PHASE_BITS-1:0] start_inc_r;
  logic [PHASE_BITS-1:0] inc_step_r;
  logic [CNT_BITS-1:0]   count_r;      // already clamped to 1 .. 2^COUNT_BITS
  logic [CNT_BITS-1:0]   count_wr;
  logic [CNT_BITS-1:0]   count_eff;

  // Clamp the count once, at write time, so stage 1 only compares.
  assign count_wr = cfg_wdata[CNT_BITS-1:0];

  always_comb begin
    count_eff = count_wr;
    if (count_wr == '0) begin
      count_eff = CNT_BITS'(1);
    end else if (count_wr > MAX_COUNT) begin
      count_eff = MAX_COUNT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amp_r       <= '0;
      start_inc_r <= '0;
      inc_step_r  <= '0;
      count_r     <= RESET_COUNT;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_AMPLITUDE:  amp_r       <= cfg_wdata[AMP_BITS-1:0];
        REG_START_INC:  start_inc_r <= cfg_wdata[PHASE_BITS-1:0];
        REG_INC_STEP:   inc_step_r  <= cfg_wdata[PHASE_BITS-1:0];
        REG_SAMPLE_CNT: count_r     <= count_eff;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline handshake: each stage moves when the next one is empty or moving
  // --------------------------------------------------------------------------
  logic v1_r, v2_r, v3_r, out_valid_r;
  logic out_rdy, rdy3, rdy2, rdy1;
  logic in_xfer, adv2, adv3, adv4;

  assign out_rdy  = !out_valid_r || !out_stall;
  assign rdy3     = !v3_r || out_rdy;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_stall = !rdy1;
  assign in_xfer  = in_valid && rdy1;
  assign adv2     = v1_r && rdy2;
  assign adv3     = v2_r && rdy3;
  assign adv4     = v3_r && out_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        v1_r <= 1'b1;
      end else if (adv2) begin
        v1_r <= 1'b0;
      end
      if (adv2) begin
        v2_r <= 1'b1;
      end else if (adv3) begin
        v2_r <= 1'b0;
      end
      if (adv3) begin
        v3_r <= 1'b1;
      end else if (adv4) begin
        v3_r <= 1'b0;
      end
      if (adv4) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: increment / phase / run index update
  //   first sample: inc = phase = start
  //   otherwise:    inc' = inc + step, phase' = phase + inc + step
  // The phase update uses a three-input add so both sums come from the old increment.
  // --------------------------------------------------------------------------
  logic [PHASE_BITS-1:0]      phase_r, phase_nxt;
  logic [PHASE_BITS-1:0]      inc_r, inc_nxt;
  logic [COUNT_BITS-1:0]      idx_r, idx_nxt;
  logic [COUNT_BITS-1:0]      idx_cur;
  logic [CNT_BITS-1:0]        idx_inc;
  logic                       first_smp;
  logic                       last_smp;
  logic [TABLE_ADDR_BITS-1:0] s1_addr_r;
  logic                       s1_last_r;

  assign idx_cur   = in_restart ? '0 : idx_r;
  assign first_smp = (idx_cur == '0);
  assign idx_inc   = {1'b0, idx_cur} + CNT_BITS'(1);
  assign last_smp  = (idx_inc >= count_r);   // also fires when count was lowered
  assign idx_nxt   = last_smp ? '0 : idx_inc[COUNT_BITS-1:0];

  always_comb begin
    if (first_smp) begin
      inc_nxt   = start_inc_r;
      phase_nxt = start_inc_r;
    end else begin
      inc_nxt   = inc_r + inc_step_r;
      phase_nxt = phase_r + inc_r + inc_step_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      inc_r   <= '0;
      idx_r   <= '0;
    end else if (in_xfer) begin
      phase_r <= phase_nxt;
      inc_r   <= inc_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_addr_r <= phase_nxt[PHASE_BITS-1 -: TABLE_ADDR_BITS];
      s1_last_r <= last_smp;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: quadrant fold and sine ROM read (registered)
  //   odd quadrants mirror the address (Q-1-k == ~k), upper half negates
  // --------------------------------------------------------------------------
  logic [1:0]              quad;
  logic [QUARTER_BITS-1:0] rom_addr;
  logic [MAG_BITS-1:0]     s2_mag_r;
  logic                    s2_neg_r;
  logic                    s2_last_r;

  assign quad     = s1_addr_r[TABLE_ADDR_BITS-1 -: 2];
  assign rom_addr = quad[0] ? ~s1_addr_r[QUARTER_BITS-1:0] : s1_addr_r[QUARTER_BITS-1:0];

  always_ff @(posedge clk) begin
    if (adv2) begin
      s2_mag_r  <= SINE_ROM[rom_addr];
      s2_neg_r  <= quad[1];
      s2_last_r <= s1_last_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: amplitude multiply
  // --------------------------------------------------------------------------
  logic [PROD_BITS-1:0] s3_prod_r;
  logic                 s3_neg_r;
  logic                 s3_last_r;

  always_ff @(posedge clk) begin
    if (adv3) begin
      s3_prod_r <= PROD_BITS'(amp_r) * PROD_BITS'(s2_mag_r);
      s3_neg_r  <= s2_neg_r;
      s3_last_r <= s2_last_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: scale by 2^-15 and apply sign
  //   positive: floor(p / 2^15)
  //   negative: -ceil(p / 2^15) == floor(-p / 2^15), i.e. shift of -p
  // --------------------------------------------------------------------------
  logic [PROD_BITS:0]    prod_neg;
  logic [SAMPLE_BITS-1:0] sample_nxt;
  logic [SAMPLE_BITS-1:0] sample_r;
  logic                   last_r;

  assign prod_neg = -{1'b0, s3_prod_r};

  always_comb begin
    if (s3_neg_r) begin
      sample_nxt = SAMPLE_BITS'(prod_neg[PROD_BITS:AMP_FRAC]);
    end else begin
      sample_nxt = SAMPLE_BITS'({1'b0, s3_prod_r[PROD_BITS-1:AMP_FRAC]});
    end
  end

  always_ff @(posedge clk) begin
    if (adv4) begin
      sample_r <= sample_nxt;
      last_r   <= s3_last_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = sample_r;
  assign out_last   = last_r;

endmodule

@@ rtl/lcsg_checker.sv @@
// ----------------------------------------------------------------------------
// lcsg_checker: port-level assertions for the chirp generator
// Bound to the top level; watches handshakes and sample range only.
// ----------------------------------------------------------------------------
module lcsg_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_valid,
  input logic                                  in_stall,
  input logic                                  out_valid,
  input logic                                  out_stall,
  input logic signed [lcsg_pkg::SAMPLE_BITS-1:0] out_sample,
  input logic                                  out_last
);

  import lcsg_pkg::*;

  localparam logic [SAMPLE_BITS-1:0] MOST_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sample) && $stable(out_last))
    else $error("stalled result changed");

  // Input backpressure only when the output side is full and held
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output free");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

  // Sine is symmetric, so the most negative code never appears
  a_sample_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_sample != MOST_NEG)
    else $error("sample out of range");

endmodule

bind linear_chirp_sine_generator lcsg_checker u_lcsg_checker (.*);
